/* hdl/msra_pkg.sv */
// Shared types, constants and register codes of the motor speed ramp and arm sequencer.
package msra_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_TARGET = 2'd1,
        OP_ESTOP  = 2'd2,
        OP_TELEM  = 2'd3
    } op_t;

    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd2;
    localparam logic [2:0] REG_STEER_VALUE = 3'd3;
    localparam logic [2:0] REG_TEL_TIMEOUT = 3'd4;

    localparam logic [15:0] FRAME_START        = 16'hABCD;
    localparam logic [4:0]  KEEPALIVE_MS       = 5'd20;
    localparam logic [4:0]  KEEPALIVE_MAX      = 5'd31;
    localparam logic [8:0]  ARM_RETRY_MS       = 9'd500;
    localparam logic [8:0]  ARM_RETRY_MAX      = 9'd511;
    localparam logic [10:0] ZERO_STOP_MS       = 11'd1500;
    localparam logic [10:0] ZERO_STOP_MAX      = 11'd2047;
    localparam logic [16:0] TEL_AGE_MAX        = 17'h1FFFF;
    localparam logic [15:0] DEFAULT_TIMEOUT_MS = 16'd1000;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] speed_value;
        logic signed [15:0] tel_rpm;
        logic               tel_armed_present;
        logic               tel_armed_flag;
    } in_t;

    typedef struct packed {
        logic               frame_valid;
        logic signed [15:0] frame_steer;
        logic signed [15:0] frame_speed;
        logic [15:0]        frame_check;
        logic               arm_strobe;
        logic               disarm_strobe;
        logic signed [15:0] ramped_speed;
        logic               arm_pending;
        logic               telemetry_stale;
    } out_t;

    typedef struct packed {
        logic               enable;
        logic [14:0]        max_speed;
        logic [14:0]        ramp_step;
        logic signed [15:0] steer_value;
        logic [15:0]        tel_timeout_ms;
    } cfg_t;

endpackage

/* hdl/msra_cfg.sv */
// Configuration register file of the sequencer.
module msra_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output msra_pkg::cfg_t     cfg
);

    msra_pkg::cfg_t cfg_reg;
    msra_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                msra_pkg::REG_ENABLE:      cfg_next.enable = cfg_data[0];
                msra_pkg::REG_MAX_SPEED:   cfg_next.max_speed = cfg_data[14:0];
                msra_pkg::REG_RAMP_STEP:
                begin
                    cfg_next.ramp_step = (cfg_data[14:0] == 15'd0) ? 15'd1 : cfg_data[14:0];
                end
                msra_pkg::REG_STEER_VALUE: cfg_next.steer_value = cfg_data;
                msra_pkg::REG_TEL_TIMEOUT: cfg_next.tel_timeout_ms = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.max_speed      <= 15'd0;
            cfg_reg.ramp_step      <= 15'd1;
            cfg_reg.steer_value    <= 16'sd0;
            cfg_reg.tel_timeout_ms <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/msra_core.sv */
// Sequencer state and the single-pass update for one event beat.
module msra_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  msra_pkg::in_t  item,
    input  msra_pkg::cfg_t cfg,
    output msra_pkg::out_t result
);

    logic signed [15:0] target_reg, target_next;
    logic signed [15:0] current_reg, current_next;
    logic [4:0]         ka_reg, ka_next;
    logic               arm_req_reg, arm_req_next;
    logic [8:0]         retry_reg, retry_next;
    logic               zs_active_reg, zs_active_next;
    logic [10:0]        zs_elapsed_reg, zs_elapsed_next;
    logic               tel_seen_reg, tel_seen_next;
    logic               tel_armed_reg, tel_armed_next;
    logic               rpm_zero_reg, rpm_zero_next;
    logic [16:0]        age_reg, age_next;

    always_comb
    begin
        logic               fv;
        logic               arm;
        logic               disarm;
        logic signed [15:0] fsteer;
        logic signed [15:0] fspeed;
        logic signed [16:0] up;
        logic signed [16:0] down;
        logic signed [16:0] tgt_w;
        logic signed [15:0] lim;
        logic signed [15:0] s;
        logic [15:0]        limit;

        fv     = 1'b0;
        arm    = 1'b0;
        disarm = 1'b0;
        fsteer = 16'sd0;
        fspeed = 16'sd0;
        tgt_w  = {target_reg[15], target_reg};
        up     = {current_reg[15], current_reg} + $signed({2'b00, cfg.ramp_step});
        down   = {current_reg[15], current_reg} - $signed({2'b00, cfg.ramp_step});
        lim    = $signed({1'b0, cfg.max_speed});
        s      = item.speed_value;

        target_next     = target_reg;
        current_next    = current_reg;
        ka_next         = ka_reg;
        arm_req_next    = arm_req_reg;
        retry_next      = retry_reg;
        zs_active_next  = zs_active_reg;
        zs_elapsed_next = zs_elapsed_reg;
        tel_seen_next   = tel_seen_reg;
        tel_armed_next  = tel_armed_reg;
        rpm_zero_next   = rpm_zero_reg;
        age_next        = age_reg;

        if (item.op == msra_pkg::OP_ESTOP)
        begin
            target_next     = 16'sd0;
            current_next    = 16'sd0;
            zs_active_next  = 1'b1;
            zs_elapsed_next = 11'd0;
            ka_next         = 5'd0;
            fv              = 1'b1;
        end
        else if (cfg.enable)
        begin
            unique case (item.op)
                msra_pkg::OP_TICK:
                begin
                    retry_next = (retry_reg < msra_pkg::ARM_RETRY_MAX) ? retry_reg + 9'd1
                                                                       : retry_reg;
                    age_next   = (age_reg < msra_pkg::TEL_AGE_MAX) ? age_reg + 17'd1 : age_reg;
                    ka_next    = (ka_reg < msra_pkg::KEEPALIVE_MAX) ? ka_reg + 5'd1 : ka_reg;
                    if (ka_next >= msra_pkg::KEEPALIVE_MS)
                    begin
                        ka_next = 5'd0;
                        if (current_reg < target_reg)
                        begin
                            current_next = (up > tgt_w) ? target_reg : up[15:0];
                        end
                        else if (current_reg > target_reg)
                        begin
                            current_next = (down < tgt_w) ? target_reg : down[15:0];
                        end
                        fv     = 1'b1;
                        fsteer = cfg.steer_value;
                        fspeed = current_next;
                    end
                    if (arm_req_reg && !tel_armed_reg && retry_next >= msra_pkg::ARM_RETRY_MS)
                    begin
                        arm        = 1'b1;
                        retry_next = 9'd0;
                    end
                    if (target_reg == 16'sd0)
                    begin
                        if (current_next == 16'sd0 && tel_seen_reg && rpm_zero_reg)
                        begin
                            if (!zs_active_reg)
                            begin
                                zs_active_next  = 1'b1;
                                zs_elapsed_next = 11'd0;
                            end
                            else if (zs_elapsed_reg < msra_pkg::ZERO_STOP_MAX)
                            begin
                                zs_elapsed_next = zs_elapsed_reg + 11'd1;
                            end
                            if (zs_elapsed_next >= msra_pkg::ZERO_STOP_MS && arm_req_reg)
                            begin
                                disarm       = 1'b1;
                                arm_req_next = 1'b0;
                            end
                        end
                        else
                        begin
                            zs_active_next  = 1'b0;
                            zs_elapsed_next = 11'd0;
                        end
                    end
                end
                msra_pkg::OP_TARGET:
                begin
                    if (s > lim)
                    begin
                        s = lim;
                    end
                    if (s < -lim)
                    begin
                        s = -lim;
                    end
                    target_next = s;
                    if (s != 16'sd0)
                    begin
                        if (!arm_req_reg)
                        begin
                            arm_req_next = 1'b1;
                            arm          = 1'b1;
                            retry_next   = 9'd0;
                        end
                    end
                    else
                    begin
                        zs_active_next  = 1'b1;
                        zs_elapsed_next = 11'd0;
                    end
                end
                msra_pkg::OP_TELEM:
                begin
                    rpm_zero_next = (item.tel_rpm == 16'sd0);
                    if (item.tel_armed_present)
                    begin
                        tel_armed_next = item.tel_armed_flag;
                    end
                    tel_seen_next = 1'b1;
                    age_next      = 17'd0;
                end
                default:
                begin
                    target_next = target_reg;
                end
            endcase
        end

        limit = (cfg.tel_timeout_ms != 16'd0) ? cfg.tel_timeout_ms
                                              : msra_pkg::DEFAULT_TIMEOUT_MS;

        result.frame_valid     = fv;
        result.frame_steer     = fsteer;
        result.frame_speed     = fspeed;
        result.frame_check     = fv ? (msra_pkg::FRAME_START ^ fsteer ^ fspeed) : 16'd0;
        result.arm_strobe      = arm;
        result.disarm_strobe   = disarm;
        result.ramped_speed    = current_next;
        result.arm_pending     = arm_req_next;
        result.telemetry_stale = cfg.enable && tel_seen_next && (age_next > {1'b0, limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= 16'sd0;
            current_reg    <= 16'sd0;
            ka_reg         <= 5'd0;
            arm_req_reg    <= 1'b0;
            retry_reg      <= 9'd0;
            zs_active_reg  <= 1'b0;
            zs_elapsed_reg <= 11'd0;
            tel_seen_reg   <= 1'b0;
            tel_armed_reg  <= 1'b0;
            rpm_zero_reg   <= 1'b0;
            age_reg        <= 17'd0;
        end
        else if (fire)
        begin
            target_reg     <= target_next;
            current_reg    <= current_next;
            ka_reg         <= ka_next;
            arm_req_reg    <= arm_req_next;
            retry_reg      <= retry_next;
            zs_active_reg  <= zs_active_next;
            zs_elapsed_reg <= zs_elapsed_next;
            tel_seen_reg   <= tel_seen_next;
            tel_armed_reg  <= tel_armed_next;
            rpm_zero_reg   <= rpm_zero_next;
            age_reg        <= age_next;
        end
    end

endmodule

/* hdl/motor_speed_ramp_arm_sequencer.sv */
// Top level of the motor speed ramp and arm sequencer: input and result registers.
//
// Usage:
//   Event beats (tick, set target, emergency stop, telemetry) enter on
//   in_valid/in_stall/in_data; one result beat per event leaves on
//   out_valid/out_stall/out_data carrying the command frame, the arm and
//   disarm strobes, the ramped speed, the arm request and the stale flag.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while no beat is in
//   flight.
//   A beat accepted is registered at the input, and its result is
//   registered in the result register once that register is free.
//   Throughput: one beat per cycle while out_stall is low; the state
//   update is one pass of logic between the input and result registers.
//   Reset clears the core state, valid flags and the registers (ramp step reads one).
//   When the receiver stalls the result holds, the input register keeps
//   its beat, and in_stall rises while the input register is occupied.
module motor_speed_ramp_arm_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  msra_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output msra_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    msra_pkg::cfg_t cfg;
    msra_pkg::in_t  item_reg;
    msra_pkg::out_t result;
    msra_pkg::out_t out_data_reg;
    logic           item_valid_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    msra_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msra_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    a_frame_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_valid |->
            out_data.frame_check ==
                (msra_pkg::FRAME_START ^ out_data.frame_steer ^ out_data.frame_speed))
        else $error("frame check word mismatch");

    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_valid |->
            out_data.frame_check == 16'd0 && out_data.frame_steer == 16'sd0 &&
            out_data.frame_speed == 16'sd0)
        else $error("idle frame fields not zero");

    a_arm_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.arm_strobe && !out_data.disarm_strobe |->
            out_data.arm_pending)
        else $error("arm strobed without a pending request");

    a_disarm_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.disarm_strobe |-> !out_data.arm_pending)
        else $error("disarm left arm request pending");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule
